// ===== design/pip_pkg.sv =====
// shared types and codes for the point-in-polygon test
// no dependencies; imported by the top level and its checker
package pip_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREV,
    ST_EDGE,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

// ===== design/pip_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/point_in_polygon_test.sv =====
// point-in-polygon test, even-odd ray crossing over a stored vertex table
// depends on pip_pkg and pip_ram
//
// usage
//   a word is taken at a rising edge with start high and busy low. action_i
//   selects append vertex, query point or clear polygon; coord_x_i and
//   coord_y_i carry signed fixed-point coordinates.
//   every word gives exactly one result: result_valid_o is high for one
//   cycle with inside_res_o, status_o and count_now_o. the receiver cannot
//   stall, so the result must be taken in that cycle.
// results and throughput
//   append, clear and the unused code: result in the next cycle, busy stays
//   low, so one word can be taken every cycle.
//   query on an empty table: result in the next cycle.
//   query on n vertices: busy while the edge walk runs. ST_PREV takes the
//   last vertex as the previous one, then ST_EDGE does each edge's table
//   read and difference stage, and a straddling edge also passes ST_MUL1,
//   ST_MUL2 on the one shared multiplier and ST_CMP for the product compare.
// reset
//   clears the vertex count, the sequencer and the result strobe; the
//   vertex table itself is not cleared, entries at or above the count are
//   never read.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16,
  localparam int CntW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  output logic                         result_valid_o,
  output logic                         inside_res_o,
  output logic                         status_o,
  output logic [CntW-1:0]              count_now_o
);

  import pip_pkg::*;

  localparam int AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DiffW = COORD_BITS + 1;   // differences of two coordinates
  localparam int ProdW = 2 * DiffW;        // exact product of two differences

  // sequencer and count
  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_m1;
  logic [AddrW-1:0] idx_q;

  // query point and the previous vertex of the walk
  logic signed [COORD_BITS-1:0] px_q, py_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;

  // per-edge operands and products
  logic signed [DiffW-1:0] dx_q, dy_q, qx_q, qy_q;
  logic                    dy_pos_q;
  logic                    last_q;
  logic signed [DiffW-1:0] mul_a, mul_b;
  logic signed [ProdW-1:0] product;
  logic signed [ProdW-1:0] p1_q, p2_q;
  logic                    in_q;

  // result registers
  logic res_valid_q, res_inside_q, res_status_q;

  // table port controls
  logic                      ram_we;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic [2*COORD_BITS-1:0]   ram_rdata;

  logic accept;
  logic is_query;
  logic is_append;
  logic is_clear;
  logic full;
  logic walk;          // query that needs the edge walk
  logic is_last;       // current vertex is the last one of the table
  logic straddle;
  logic left;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign is_query  = (action_i == ACT_QUERY);
  assign is_append = (action_i == ACT_APPEND);
  assign is_clear  = (action_i == ACT_CLEAR);
  assign full      = (cnt_q == CntW'(MAX_VERTICES));
  assign walk      = accept && is_query && (cnt_q != '0);
  assign cnt_m1    = cnt_q - 1'b1;
  assign is_last   = (CntW'(idx_q) == cnt_m1);

  assign cur_x = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign cur_y = ram_rdata[COORD_BITS-1:0];

  // edge (current vertex i, previous vertex j) straddles the point's y,
  // lower end inclusive, upper end exclusive
  assign straddle = ((cur_y <= py_q) && (py_q < prev_y_q)) ||
                    ((prev_y_q <= py_q) && (py_q < cur_y));

  // point left of the crossing: qx*dy < dx*qy, flipped when dy is negative
  assign left = dy_pos_q ? (p1_q < p2_q) : (p2_q < p1_q);

  // shared multiplier: first qx*dy, then dx*qy
  assign mul_a   = (state_q == ST_MUL1) ? qx_q : dx_q;
  assign mul_b   = (state_q == ST_MUL1) ? dy_q : qy_q;
  assign product = ProdW'(mul_a) * ProdW'(mul_b);

  // vertex table, x in the upper half of the word
  assign ram_we = accept && is_append && !full;

  pip_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(cnt_q)),
    .wdata_i ({coord_x_i, coord_y_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (walk) begin
          state_d = ST_PREV;
        end
      end
      ST_PREV: state_d = ST_EDGE;
      ST_EDGE: begin
        if (straddle) begin
          state_d = ST_MUL1;
        end else if (is_last) begin
          state_d = ST_DONE;
        end
      end
      ST_MUL1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_CMP;
      ST_CMP:  state_d = last_q ? ST_DONE : ST_EDGE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // table read control: last vertex first, then vertices 0 .. n-1
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        ram_re    = walk;
        ram_raddr = AddrW'(cnt_m1);
      end
      ST_PREV: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_EDGE: begin
        // the read data then holds through the multiply steps
        ram_re    = !is_last;
        ram_raddr = idx_q + 1'b1;
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  // vertex count
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (is_append && !full) begin
        cnt_d = cnt_q + 1'b1;
      end else if (is_clear) begin
        cnt_d = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      in_q         <= 1'b0;
      res_valid_q  <= 1'b0;
      res_inside_q <= 1'b0;
      res_status_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;

      if (state_q == ST_PREV) begin
        in_q <= 1'b0;
      end else if ((state_q == ST_CMP) && left) begin
        in_q <= !in_q;
      end

      // one strobe per word: at once unless the edge walk runs
      res_valid_q <= (accept && !walk) || (state_q == ST_DONE);
      if (state_q == ST_DONE) begin
        res_inside_q <= in_q;
        res_status_q <= 1'b0;
      end else if (accept) begin
        res_inside_q <= 1'b0;
        res_status_q <= is_append && full;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    case (state_q)
      ST_PREV: begin
        prev_x_q <= cur_x;
        prev_y_q <= cur_y;
        idx_q    <= '0;
      end
      ST_EDGE: begin
        dx_q     <= DiffW'(prev_x_q) - DiffW'(cur_x);
        dy_q     <= DiffW'(prev_y_q) - DiffW'(cur_y);
        qx_q     <= DiffW'(px_q) - DiffW'(cur_x);
        qy_q     <= DiffW'(py_q) - DiffW'(cur_y);
        dy_pos_q <= (prev_y_q > cur_y);
        last_q   <= is_last;
        prev_x_q <= cur_x;
        prev_y_q <= cur_y;
        idx_q    <= idx_q + 1'b1;
      end
      ST_MUL1: p1_q <= product;
      ST_MUL2: p2_q <= product;
      default: begin
      end
    endcase
  end

  assign result_valid_o = res_valid_q;
  assign inside_res_o   = res_inside_q;
  assign status_o       = res_status_q;
  assign count_now_o    = cnt_q;

endmodule

// ===== design/pip_checker.sv =====
// port-level checks for the point-in-polygon test
// depends on pip_pkg; bound to point_in_polygon_test
module pip_port_checks #(
  parameter int MAX_VERTICES = 64,
  localparam int CntW = $clog2(MAX_VERTICES + 1)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic [1:0]      action_i,
  input logic            result_valid_o,
  input logic            inside_res_o,
  input logic            status_o,
  input logic [CntW-1:0] count_now_o
);

  import pip_pkg::*;

  // no result while the edge walk still runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // a word other than a query is answered in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i != ACT_QUERY)) |=> result_valid_o)
    else $error("missing result for non-query word");

  // the end of a walk always delivers its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("walk ended without result");

  // a dropped append never reports inside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o) |-> !inside_res_o)
    else $error("dropped append flagged inside");

  // the count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_now_o <= CntW'(MAX_VERTICES))
    else $error("vertex count beyond table depth");

endmodule

bind point_in_polygon_test pip_port_checks #(
  .MAX_VERTICES (MAX_VERTICES)
) u_pip_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .action_i       (action_i),
  .result_valid_o (result_valid_o),
  .inside_res_o   (inside_res_o),
  .status_o       (status_o),
  .count_now_o    (count_now_o)
);

// ===== bench/pip_checker.sv =====
`timescale 1ns / 100ps
// result checker for point_in_polygon_test: keeps its own vertex table,
// predicts every accepted word's result and compares it; depends on pip_pkg
module pip_checker #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16,
  localparam int CntW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [1:0]                   action_i,
  input  logic signed [COORD_BITS-1:0] coord_x_i,
  input  logic signed [COORD_BITS-1:0] coord_y_i,
  input  logic                         result_valid_o,
  input  logic                         inside_res_o,
  input  logic                         status_o,
  input  logic [CntW-1:0]              count_now_o,
  output int                           fail_count_o,
  output int                           outstanding_o
);

  import pip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 4;

  typedef struct packed {
    logic            in_poly;
    logic            status;
    logic [CntW-1:0] count;
  } outcome_t;

  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  int       poly_len;
  outcome_t outcome_q [$];
  int       errors;

  // even-odd ray crossing, the crossing x compared by cross-multiplication
  function automatic logic crossing_parity(input logic signed [COORD_BITS-1:0] px,
                                           input logic signed [COORD_BITS-1:0] py);
    logic                 odd;
    int                   j;
    logic signed [DW-1:0] dx, dy, qx, qy;
    logic signed [PW-1:0] lhs, rhs;
    logic                 left_of;
    odd = 1'b0;
    if (poly_len == 0) return 1'b0;
    j = poly_len - 1;
    for (int i = 0; i < poly_len; i++) begin
      if ((poly_y[i] <= py && py < poly_y[j]) || (poly_y[j] <= py && py < poly_y[i])) begin
        dy = poly_y[j] - poly_y[i];
        dx = poly_x[j] - poly_x[i];
        qy = py - poly_y[i];
        qx = px - poly_x[i];
        lhs = qx * dy;
        rhs = dx * qy;
        // dividing by a negative height flips the inequality
        left_of = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (left_of) odd = !odd;
      end
      j = i;
    end
    return odd;
  endfunction

  function automatic outcome_t apply_word(input logic [1:0] act,
                                          input logic signed [COORD_BITS-1:0] x,
                                          input logic signed [COORD_BITS-1:0] y);
    outcome_t o;
    o = '0;
    case (act)
      ACT_APPEND: begin
        if (poly_len < MAX_VERTICES) begin
          poly_x[poly_len] = x;
          poly_y[poly_len] = y;
          poly_len++;
        end else begin
          o.status = 1'b1;
        end
      end
      ACT_QUERY: o.in_poly = crossing_parity(x, y);
      ACT_CLEAR: poly_len = 0;
      default: ;
    endcase
    o.count = CntW'(poly_len);
    return o;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // results are compared before the word taken at the same edge is added
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      outcome_q.delete();
      poly_len = 0;
      errors = 0;
      outstanding_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (result_valid_o) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual inside %0b status %0b count %0d",
                   $time, inside_res_o, status_o, count_now_o);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          check_field("inside_res", 32'(want.in_poly), 32'(inside_res_o));
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("count_now", 32'(want.count), 32'(count_now_o));
        end
      end
      if (start && !busy) outcome_q.push_back(apply_word(action_i, coord_x_i, coord_y_i));
      outstanding_o <= outcome_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// top of the point_in_polygon_test bench: clock, reset and word stimulus
// depends on pip_pkg, point_in_polygon_test and pip_checker
module tb;
  import pip_pkg::*;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int CntW         = $clog2(MAX_VERTICES + 1);
  localparam int WORD_TARGET  = 1950;
  localparam int COORD_MIN    = -(2 ** (COORD_BITS - 1));
  localparam int COORD_MAX    = 2 ** (COORD_BITS - 1) - 1;
  // the one action code the block has no use for
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic [1:0]                   action_i = '0;
  logic signed [COORD_BITS-1:0] coord_x_i = '0;
  logic signed [COORD_BITS-1:0] coord_y_i = '0;
  logic                         busy;
  logic                         result_valid_o;
  logic                         inside_res_o;
  logic                         status_o;
  logic [CntW-1:0]              count_now_o;
  int                           fail_count;
  int                           outstanding;
  int                           words_sent = 0;
  logic                         idle_on = 1'b1;

  point_in_polygon_test #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .result_valid_o(result_valid_o),
    .inside_res_o  (inside_res_o),
    .status_o      (status_o),
    .count_now_o   (count_now_o)
  );

  pip_checker #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .result_valid_o(result_valid_o),
    .inside_res_o  (inside_res_o),
    .status_o      (status_o),
    .count_now_o   (count_now_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always #1 clk_i = ~clk_i;

  // hard stop, far beyond the slowest legal run (about 1.2 ms)
  initial begin
    #5_000_000;
    $display("point_in_polygon_test test failed");
    $finish;
  end

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // hold the word until the block takes it, then maybe idle a while
  task automatic put_word(input logic [1:0] act, input int x, input int y);
    int gap;
    start <= 1'b1;
    action_i <= act;
    coord_x_i <= COORD_BITS'(x);
    coord_y_i <= COORD_BITS'(y);
    do @(posedge clk_i); while (busy);
    if (act != ACT_SPARE) words_sent++;
    if (idle_on && $urandom_range(0, 99) < 30) begin
      // mostly short gaps, now and then a long one
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending until every pending result has come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // clear, build a polygon in a random window, then probe it
  task automatic polygon_round();
    int n_vert, n_query, k, lo_x, hi_x, lo_y, hi_y, c, r, qx, qy;
    int xs[$];
    int ys[$];
    if ($urandom_range(0, 4) == 0) begin
      lo_x = COORD_MIN; hi_x = COORD_MAX;
      lo_y = COORD_MIN; hi_y = COORD_MAX;
    end else begin
      r = $urandom_range(4, 2000);
      c = pick(-30000, 30000);
      lo_x = (c - r < COORD_MIN) ? COORD_MIN : c - r;
      hi_x = (c + r > COORD_MAX) ? COORD_MAX : c + r;
      c = pick(-30000, 30000);
      lo_y = (c - r < COORD_MIN) ? COORD_MIN : c - r;
      hi_y = (c + r > COORD_MAX) ? COORD_MAX : c + r;
    end
    k = $urandom_range(0, 99);
    if (k < 4) n_vert = MAX_VERTICES;
    else if (k < 14) n_vert = $urandom_range(9, 24);
    else if (k < 18) n_vert = $urandom_range(1, 2);
    else n_vert = $urandom_range(3, 8);

    put_word(ACT_CLEAR, pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX));
    for (int v = 0; v < n_vert; v++) begin
      xs.push_back(pick(lo_x, hi_x));
      // repeating the last y makes a horizontal edge
      if (ys.size() > 0 && $urandom_range(0, 5) == 0) ys.push_back(ys[$]);
      else ys.push_back(pick(lo_y, hi_y));
      put_word(ACT_APPEND, xs[$], ys[$]);
    end
    // appends against a full table get dropped
    if (n_vert == MAX_VERTICES)
      repeat ($urandom_range(1, 3)) put_word(ACT_APPEND, pick(lo_x, hi_x), pick(lo_y, hi_y));

    n_query = $urandom_range(2, 6);
    repeat (n_query) begin
      k = $urandom_range(0, 99);
      qx = (k < 10) ? xs[$urandom_range(0, xs.size() - 1)] : pick(lo_x, hi_x);
      // a y right on a vertex probes the inclusive and exclusive ends
      qy = (k >= 75) ? ys[$urandom_range(0, ys.size() - 1)] : pick(lo_y, hi_y);
      put_word(ACT_QUERY, qx, qy);
    end
  endtask

  // short runs of unrelated words, including the spare code
  task automatic noise_round();
    logic [1:0] act;
    repeat ($urandom_range(1, 6)) begin
      act = ($urandom_range(0, 19) == 0) ? ACT_SPARE : 2'($urandom_range(0, 2));
      put_word(act, pick(COORD_MIN, COORD_MAX), pick(COORD_MIN, COORD_MAX));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, spare code, lone vertex and a two-vertex table
    put_word(ACT_QUERY, 0, 0);
    put_word(ACT_SPARE, -1, -1);
    put_word(ACT_CLEAR, 0, 0);
    put_word(ACT_APPEND, COORD_MAX, COORD_MAX);
    put_word(ACT_QUERY, 0, COORD_MAX);
    put_word(ACT_APPEND, COORD_MIN, COORD_MIN);
    put_word(ACT_QUERY, COORD_MIN, 0);
    // triangle spanning the coordinate extremes
    put_word(ACT_APPEND, COORD_MAX, COORD_MIN);
    put_word(ACT_QUERY, COORD_MAX, 0);
    put_word(ACT_QUERY, 0, 0);
    put_word(ACT_QUERY, COORD_MIN, COORD_MAX);
    put_word(ACT_QUERY, 1000, COORD_MIN);
    // square with horizontal edges, probed on and around its border
    put_word(ACT_CLEAR, COORD_MAX, COORD_MIN);
    put_word(ACT_APPEND, 0, 0);
    put_word(ACT_APPEND, 160, 0);
    put_word(ACT_APPEND, 160, 160);
    put_word(ACT_APPEND, 0, 160);
    put_word(ACT_QUERY, 80, 80);
    put_word(ACT_QUERY, 80, 0);
    put_word(ACT_QUERY, 80, 160);
    put_word(ACT_QUERY, 0, 80);
    put_word(ACT_QUERY, 160, 80);
    put_word(ACT_QUERY, -1, 80);
    put_word(ACT_QUERY, 200, 80);
    drain();

    while (words_sent < WORD_TARGET) begin
      // some rounds run back to back with no idling at all
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) polygon_round();
      else noise_round();
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    // longer than the slowest query, to catch stray results
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("point_in_polygon_test test passed");
    end else begin
      $display("point_in_polygon_test test failed");
    end
    $finish;
  end

endmodule

// ===== point_in_polygon_test.f =====
design/pip_pkg.sv
design/pip_ram.sv
design/point_in_polygon_test.sv
design/pip_checker.sv
bench/pip_checker.sv
bench/tb.sv
